// ===== rtl/bdll_pkg.sv =====
// Package for the bounded doubly linked list core: action and status codes,
// controller command/status structs. No dependencies.
package bdll_pkg;
    localparam int unsigned DefCapacity  = 32;
    localparam int unsigned DefDataWidth = 32;
    localparam int unsigned LinkW        = 7;

    localparam logic [2:0] ActInsFront = 3'd0;
    localparam logic [2:0] ActInsBack  = 3'd1;
    localparam logic [2:0] ActDelVal   = 3'd2;
    localparam logic [2:0] ActDelPos   = 3'd3;
    localparam logic [2:0] ActDisplay  = 3'd4;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StEmpty    = 2'd1;
    localparam logic [1:0] StNotFound = 2'd2;
    localparam logic [1:0] StFull     = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_LOAD   = 3'd1, // latch request, cursor <= head
        OP_INSERT = 3'd2, // link a free slot at front/back
        OP_FETCH  = 3'd3, // read cursor slot
        OP_ADV    = 3'd4, // cursor <= next of fetched slot
        OP_UNLK1  = 3'd5, // unlink, step 1: fix prev's next / head
        OP_UNLK2  = 3'd6  // unlink, step 2: fix next's prev / tail, free slot
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       list_empty;
        logic       free_empty;
        logic       cur_null;
        logic       match;      // fetched value equals key
        logic       pos_hit;    // step count reached max(position,1)-1
        logic       step_limit; // visited CAPACITY slots
        logic       next_null;  // fetched slot's next is null
    } t_sts;
endpackage

// ===== rtl/bdll_datapath.sv =====
// Datapath of the linked list core: slot memories, head/tail/free registers,
// cursor and request registers. Depends on bdll_pkg.
module bdll_datapath
    import bdll_pkg::*;
#(
    parameter int unsigned CAPACITY   = DefCapacity,
    parameter int unsigned DATA_WIDTH = DefDataWidth
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [2:0]            i_action,
    input  logic [31:0]           i_item_value,
    input  logic [5:0]            i_position,
    output t_sts                  o_sts,
    output logic [31:0]           o_fetch_value
);
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [LinkW-1:0] Nil = LinkW'(CAPACITY);

    logic [DATA_WIDTH-1:0] r_vals [CAPACITY];
    logic [LinkW-1:0]      r_prev [CAPACITY];
    logic [LinkW-1:0]      r_next [CAPACITY];
    logic [LinkW-1:0]      r_head, r_tail, r_free;
    logic [LinkW-1:0]      r_cur, r_fnext, r_fprev;
    logic [DATA_WIDTH-1:0] r_fval, r_key;
    logic [2:0]            r_action;
    logic [5:0]            r_pos;
    logic [LinkW-1:0]      r_steps;

    logic [IW-1:0] cur_i, free_i, head_i, tail_i, fp_i, fn_i;
    assign cur_i  = r_cur[IW-1:0];
    assign free_i = r_free[IW-1:0];
    assign head_i = r_head[IW-1:0];
    assign tail_i = r_tail[IW-1:0];
    assign fp_i   = r_fprev[IW-1:0];
    assign fn_i   = r_fnext[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= Nil;
            r_tail <= Nil;
            r_free <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_next[i] <= LinkW'(i + 1);
            end
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_action <= i_action;
                    // key kept as the low DATA_WIDTH bits of the sign-extended input
                    r_key    <= DATA_WIDTH'($signed(i_item_value));
                    r_pos    <= i_position;
                    r_cur    <= r_head;
                    r_steps  <= '0;
                end
                OP_INSERT: begin
                    r_free        <= r_next[free_i];
                    r_vals[free_i] <= r_key;
                    if (r_head == Nil) begin
                        r_next[free_i] <= Nil;
                        r_prev[free_i] <= Nil;
                        r_head <= r_free;
                        r_tail <= r_free;
                    end else if (r_action == ActInsFront) begin
                        r_next[free_i] <= r_head;
                        r_prev[free_i] <= Nil;
                        r_prev[head_i] <= r_free;
                        r_head <= r_free;
                    end else begin
                        r_next[free_i] <= Nil;
                        r_prev[free_i] <= r_tail;
                        r_next[tail_i] <= r_free;
                        r_tail <= r_free;
                    end
                end
                OP_FETCH: begin
                    r_fval  <= r_vals[cur_i];
                    r_fnext <= r_next[cur_i];
                    r_fprev <= r_prev[cur_i];
                end
                OP_ADV: begin
                    r_cur   <= r_fnext;
                    r_steps <= r_steps + 1'b1;
                end
                OP_UNLK1: begin
                    if (r_fprev != Nil) r_next[fp_i] <= r_fnext;
                    else                r_head       <= r_fnext;
                end
                OP_UNLK2: begin
                    if (r_fnext != Nil) r_prev[fn_i] <= r_fprev;
                    else                r_tail       <= r_fprev;
                    r_next[cur_i] <= r_free;
                    r_free        <= r_cur;
                end
                default: ;
            endcase
        end
    end

    // position q selects element max(q,1); r_steps counts links taken
    logic [6:0] pos_m1;
    assign pos_m1 = (r_pos == 6'd0) ? 7'd0 : {1'b0, r_pos} - 7'd1;

    assign o_sts.action     = r_action;
    assign o_sts.list_empty = (r_head == Nil);
    assign o_sts.free_empty = (r_free == Nil);
    assign o_sts.cur_null   = (r_cur == Nil);
    assign o_sts.match      = (r_fval == r_key);
    assign o_sts.pos_hit    = (7'(r_steps) >= pos_m1);
    assign o_sts.step_limit = (r_steps >= LinkW'(CAPACITY - 1));
    assign o_sts.next_null  = (r_fnext == Nil);
    assign o_fetch_value    = 32'($signed(r_fval));
endmodule

// ===== rtl/bdll_ctrl.sv =====
// Controller state machine of the linked list core; drives datapath commands
// and the output register. Depends on bdll_pkg.
module bdll_ctrl
    import bdll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic [2:0]  i_action,
    output logic        o_in_ready,
    input  t_sts        i_sts,
    input  logic [31:0] i_fetch_value,
    output t_cmd        o_cmd,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_value,
    output logic        o_value_valid,
    output logic        o_last
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_FETCH = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_UNLK1 = 7'b0010000,
        S_UNLK2 = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ov;
    logic   out_free, emit;
    logic [1:0]  e_status;
    logic [31:0] e_value;
    logic        e_vv, e_last;

    assign out_free   = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ov;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        emit     = 1'b0;
        e_status = StOk;
        e_value  = '0;
        e_vv     = 1'b0;
        e_last   = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_action <= ActDisplay) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (out_free) begin
                    if (i_sts.action == ActInsFront || i_sts.action == ActInsBack) begin
                        emit = 1'b1;
                        if (i_sts.free_empty) e_status = StFull;
                        else o_cmd.op = OP_INSERT;
                        n_state = S_IDLE;
                    end else if (i_sts.list_empty) begin
                        emit = 1'b1;
                        e_status = StEmpty;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                if (i_sts.cur_null) begin
                    emit = 1'b1;
                    e_status = StNotFound;
                    n_state = S_WAIT;
                end else begin
                    o_cmd.op = OP_FETCH;
                    n_state  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.action == ActDisplay) begin
                    if (out_free) begin
                        emit = 1'b1;
                        e_value = i_fetch_value;
                        e_vv = 1'b1;
                        e_last = i_sts.next_null || i_sts.step_limit;
                        if (e_last) n_state = S_IDLE;
                        else begin
                            o_cmd.op = OP_ADV;
                            n_state = S_FETCH;
                        end
                    end
                end else if ((i_sts.action == ActDelVal) ? i_sts.match : i_sts.pos_hit) begin
                    n_state = S_UNLK1;
                end else if (i_sts.action == ActDelVal && i_sts.step_limit) begin
                    emit = 1'b1;
                    e_status = StNotFound;
                    n_state = S_WAIT;
                end else begin
                    o_cmd.op = OP_ADV;
                    n_state = S_FETCH;
                end
            end
            S_UNLK1: begin
                o_cmd.op = OP_UNLK1;
                n_state  = S_UNLK2;
            end
            S_UNLK2: begin
                o_cmd.op = OP_UNLK2;
                emit = 1'b1;
                e_value = i_fetch_value;
                e_vv = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // emit in FETCH/UNLK2 only follows DISP which required out_free; the
    // output register is therefore empty there, so emit_ok passes emit unguarded
    logic emit_ok;
    assign emit_ok = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit_ok) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_ok) begin
            o_status      <= e_status;
            o_value       <= e_value;
            o_value_valid <= e_vv;
            o_last        <= e_last;
        end
    end
endmodule

// ===== rtl/bounded_doubly_linked_list_core.sv =====
// Top level of the bounded doubly linked list core: controller plus datapath.
// Depends on bdll_pkg, bdll_ctrl, bdll_datapath.
//
// Holds up to CAPACITY signed values in a doubly linked pool with a free
// chain. Each input transfer carries an action (insert front/back, delete by
// value, delete by position, display). Inserts link a free slot without a
// walk; deletes and display walk the list from the head, reading one slot
// at a time. Display gives one output transfer per element with tlast on the
// tail; other actions give one transfer. Unused action codes are dropped.
// The output register holds a result until taken; a new item is taken once
// the previous one has finished.
module bounded_doubly_linked_list_core
    import bdll_pkg::*;
#(
    parameter int unsigned CAPACITY   = DefCapacity,
    parameter int unsigned DATA_WIDTH = DefDataWidth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // action[2:0], item_value[34:3], position[40:35]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // status[1:0], out_value[33:2], value_valid[34]
    output logic        m_axis_tlast
);
    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] fetch_value, ovalue;
    logic [1:0]  ostatus;
    logic        ovv;

    bdll_datapath #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk, .i_rst_n,
        .i_cmd(cmd),
        .i_action(s_axis_tdata[2:0]),
        .i_item_value(s_axis_tdata[34:3]),
        .i_position(s_axis_tdata[40:35]),
        .o_sts(sts),
        .o_fetch_value(fetch_value)
    );

    bdll_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid),
        .i_action(s_axis_tdata[2:0]),
        .o_in_ready(s_axis_tready),
        .i_sts(sts),
        .i_fetch_value(fetch_value),
        .o_cmd(cmd),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_status(ostatus),
        .o_value(ovalue),
        .o_value_valid(ovv),
        .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, ovv, ovalue, ostatus};
endmodule

// ===== sim/tb_top.sv =====
// Testbench for bounded_doubly_linked_list_core: random and directed list actions,
// checked against an in-bench model of the slot pool. Depends on bdll_pkg and the core.
module tb_top;
    import bdll_pkg::*;

    localparam int Cap = 32;
    localparam int Nil = Cap;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // action, item_value, position
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // status, out_value, value_valid
    logic        m_axis_tlast;

    bounded_doubly_linked_list_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [5:0]  position;
        logic [31:0] item_value;
        logic [2:0]  action;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_value;
        logic        value_valid;
        logic        last;
    } t_res;

    t_req  pending_q[$];
    t_res  expected_q[$];

    // list model: slot pool with free chain
    logic [31:0] pool_val[Cap];
    int          pool_next[Cap];
    int          pool_prev[Cap];
    int          head_s, tail_s, free_s, n_elem;
    int          errors = 0;
    int          n_checked = 0;
    longint      cycles = 0;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;

    function automatic t_res mk(logic [1:0] st, logic [31:0] v, logic vv, logic l);
        t_res r;
        r.status = st; r.out_value = v; r.value_valid = vv; r.last = l;
        return r;
    endfunction

    function automatic logic [31:0] unlink(int s);
        int p, n;
        p = pool_prev[s];
        n = pool_next[s];
        if (p != Nil) pool_next[p] = n; else head_s = n;
        if (n != Nil) pool_prev[n] = p; else tail_s = p;
        pool_next[s] = free_s;
        free_s = s;
        n_elem--;
        return pool_val[s];
    endfunction

    // applies one action to the model and queues the results it produces
    function automatic void predict_list_action(t_req rq);
        int s, k, cur;
        logic [1:0] st;
        case (rq.action)
            ActInsFront, ActInsBack: begin
                st = StFull;
                if (free_s != Nil) begin
                    s = free_s;
                    free_s = pool_next[s];
                    pool_val[s] = rq.item_value;
                    st = StOk;
                    if (head_s == Nil) begin
                        pool_next[s] = Nil; pool_prev[s] = Nil;
                        head_s = s; tail_s = s;
                    end else if (rq.action == ActInsFront) begin
                        pool_next[s] = head_s; pool_prev[s] = Nil;
                        pool_prev[head_s] = s; head_s = s;
                    end else begin
                        pool_next[s] = Nil; pool_prev[s] = tail_s;
                        pool_next[tail_s] = s; tail_s = s;
                    end
                    n_elem++;
                end
                expected_q.push_back(mk(st, '0, 1'b0, 1'b1));
            end
            ActDelVal: begin
                if (head_s == Nil) expected_q.push_back(mk(StEmpty, '0, 1'b0, 1'b1));
                else begin
                    cur = head_s;
                    while (cur != Nil && pool_val[cur] != rq.item_value)
                        cur = pool_next[cur];
                    if (cur == Nil) expected_q.push_back(mk(StNotFound, '0, 1'b0, 1'b1));
                    else expected_q.push_back(mk(StOk, unlink(cur), 1'b1, 1'b1));
                end
            end
            ActDelPos: begin
                if (head_s == Nil) expected_q.push_back(mk(StEmpty, '0, 1'b0, 1'b1));
                else begin
                    cur = head_s;
                    for (k = 1; k < rq.position && cur != Nil; k++) cur = pool_next[cur];
                    if (cur == Nil) expected_q.push_back(mk(StNotFound, '0, 1'b0, 1'b1));
                    else expected_q.push_back(mk(StOk, unlink(cur), 1'b1, 1'b1));
                end
            end
            ActDisplay: begin
                if (head_s == Nil) expected_q.push_back(mk(StEmpty, '0, 1'b0, 1'b1));
                else begin
                    cur = head_s;
                    while (cur != Nil) begin
                        expected_q.push_back(mk(StOk, pool_val[cur], 1'b1,
                                                pool_next[cur] == Nil));
                        cur = pool_next[cur];
                    end
                end
            end
            default: ;  // unused codes: dropped by the core
        endcase
    endfunction

    function automatic t_req req(logic [2:0] a, logic [31:0] v, logic [5:0] p);
        t_req r;
        r.action = a; r.item_value = v; r.position = p;
        return r;
    endfunction

    // values mostly drawn from a small set so deletes by value often hit
    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFC + $urandom_range(0, 3);
            2: return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // driver: bursts with random gaps; the queue head is the item on the bus
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_list_action(t_req'(s_axis_tdata[40:0]));
                void'(pending_q.pop_front());
            end
            if (s_axis_tvalid && !(s_axis_tready)) begin
                // hold the current item
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (hold_off || pending_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'd0, pending_q[0]};
                if (burst_left > 0) burst_left <= burst_left - 1;
                else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
    end

    // monitor: receiver stalls follow a phase pattern, sometimes none at all
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[34],
                       m_axis_tlast};
                n_checked++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result transfer %h", got);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
                    end
                    if (got.out_value !== exp_r.out_value) begin
                        $error("out_value exp %h got %h", exp_r.out_value, got.out_value);
                        errors++;
                    end
                    if (got.value_valid !== exp_r.value_valid) begin
                        $error("value_valid exp %b got %b", exp_r.value_valid,
                               got.value_valid);
                        errors++;
                    end
                    if (got.last !== exp_r.last) begin
                        $error("last exp %b got %b", exp_r.last, got.last); errors++;
                    end
                end
            end
            if ((cycles / 2000) % 3 == 0) m_axis_tready <= 1'b1;
            else m_axis_tready <= ((cycles % 7) < 3) || ($urandom_range(0, 3) == 0);
        end
    end

    initial begin : stim
        int i, k;
        t_req r;
        head_s = Nil; tail_s = Nil; free_s = 0; n_elem = 0;
        for (i = 0; i < Cap; i++) begin
            pool_next[i] = i + 1; pool_prev[i] = Nil; pool_val[i] = '0;
        end
        // directed: empty cases, extremes, full, positions
        pending_q.push_back(req(ActDisplay, 0, 0));
        pending_q.push_back(req(ActDelVal, 5, 0));
        pending_q.push_back(req(ActDelPos, 0, 0));
        pending_q.push_back(req(3'd7, 32'hFFFF_FFFF, 6'h3F));
        pending_q.push_back(req(3'd5, 0, 0));
        pending_q.push_back(req(3'd6, 0, 0));
        pending_q.push_back(req(ActInsFront, 32'h8000_0000, 0));
        pending_q.push_back(req(ActInsBack, 32'h7FFF_FFFF, 0));
        pending_q.push_back(req(ActInsFront, 32'hFFFF_FFFF, 0));
        pending_q.push_back(req(ActDisplay, 0, 0));
        pending_q.push_back(req(ActDelVal, 32'h1234, 0));
        pending_q.push_back(req(ActDelPos, 32'd0, 6'd63));
        pending_q.push_back(req(ActDelPos, 0, 6'd1));
        pending_q.push_back(req(ActDelVal, 32'h7FFF_FFFF, 0));
        pending_q.push_back(req(ActDelPos, 0, 6'd0));
        for (i = 0; i < 33; i++) pending_q.push_back(req(i[0], i, 0));  // fill, then full
        pending_q.push_back(req(ActDisplay, 0, 0));
        pending_q.push_back(req(ActDelPos, 0, 6'd32));
        pending_q.push_back(req(ActDelPos, 0, 6'd33));
        pending_q.push_back(req(ActDelPos, 0, 6'd2));
        for (i = 0; i < 30; i++) pending_q.push_back(req(ActDelPos, 0, 6'd0));
        // random: mix with a few unused codes, biased towards inserting or draining
        for (i = 0; i < 270; i++) begin
            k = $urandom_range(0, 99);
            r.item_value = rand_val();
            r.position = $urandom_range(0, 63);
            if (r.position > 40) r.position = $urandom_range(0, 8);
            if ((i / 60) % 2 == 0) r.action = (k < 55) ? k % 2 : (k < 75) ? ActDelVal
                : (k < 90) ? ActDelPos : (k < 97) ? ActDisplay : $urandom_range(5, 7);
            else r.action = (k < 25) ? k % 2 : (k < 55) ? ActDelVal
                : (k < 85) ? ActDelPos : (k < 97) ? ActDisplay : $urandom_range(5, 7);
            if (r.action == ActDelPos && k % 5 == 0) r.position = 6'h3F;
            pending_q.push_back(r);
            if (i == 120) begin
                // let the core drain completely once
                wait (pending_q.size() == 0);
                hold_off = 1'b1;
                wait (expected_q.size() == 0);
                repeat (80) @(posedge i_clk);
                hold_off = 1'b0;
            end
        end
        stim_done = 1'b1;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            begin
                wait (stim_done && pending_q.size() == 0 && !s_axis_tvalid &&
                      expected_q.size() == 0);
                repeat (200) @(posedge i_clk);
            end
            begin
                wait (cycles > 400000);
                $display("tb_top: done, errors");
                $finish;
            end
        join_any
        $display("ran ~350 list actions incl. full/empty/not-found cases, %0d results checked",
                 n_checked);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
